[sv/ptmut_pkg.sv]
package ptmut_pkg;

  // one table holds 512 entries, indexed by nine address bits per level
  localparam int unsigned IdxW    = 9;
  localparam int unsigned PageLsb = 12;
  localparam int unsigned AddrW   = 48;
  localparam int unsigned EntryW  = 64;

  // valid and type bits of links and leaves
  localparam logic [EntryW-1:0] EntryLowBits = 64'h3;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_MAP   = 2'd0;
  localparam kind_t KIND_UNMAP = 2'd1;
  localparam kind_t KIND_XLATE = 2'd2;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_NOT_MAPPED = 2'd1,
    ST_NO_TABLES  = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic    clear_wr;
    logic    load_item;
    logic    follow;
    logic    alloc;
    logic    leaf_wr;
    logic    res_set;
    logic    res_xlate;
    status_e res_status;
    logic    load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  level2;
    logic  level3;
    logic  link_ok;
    logic  leaf_valid;
    logic  fits;
    logic  clear_last;
  } sts_t;

endpackage

[sv/page_table_map_unmap_translate_top.sv]
// four-level page table walker over a private pool of TABLE_COUNT tables of 512 64-bit
// entries, table 0 being the root. each input transfer is a map, unmap or translate of one
// 4 KB page; each gives exactly one output transfer with a status and, for a successful
// translate, the physical address. map allocates missing tables in pool order and answers
// out-of-tables, changing nothing, when the pool cannot cover the walk. after reset the
// block zeroes the whole pool, one entry per cycle, with tready low. items are handled one
// at a time: every level of the walk is a dependent read of the single-port table memory with
// registered read data, every new table link and the leaf update take a write each, and the
// result then passes from a result register to the output register. the next item is taken
// while the previous result still waits in the output register.
module page_table_map_unmap_translate_top
  import ptmut_pkg::*;
#(
  parameter int unsigned TABLE_COUNT = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // virt_addr [47:0], phys_addr_in [95:48], attr_flags [159:96]
  input  logic [159:0] s_axis_tdata,
  // kind [1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // phys_addr_out [47:0]
  output logic [47:0]  m_axis_tdata,
  // status [1:0]
  output logic [1:0]   m_axis_tuser
);

  cmd_t    cmd;
  sts_t    sts;
  status_e out_status;

  // sequencing of walk, allocation and result transfer
  ptmut_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // item registers, table memory, pool counter and result registers
  ptmut_dp #(
    .TABLE_COUNT(TABLE_COUNT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .kind_i        (s_axis_tuser),
    .virt_addr_i   (s_axis_tdata[47:0]),
    .phys_addr_in_i(s_axis_tdata[95:48]),
    .attr_flags_i  (s_axis_tdata[159:96]),
    .out_status_o  (out_status),
    .out_phys_o    (m_axis_tdata)
  );

  assign m_axis_tuser = out_status;

endmodule

[sv/ptmut_ram.sv]
module ptmut_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[sv/ptmut_ctrl.sv]
module ptmut_ctrl
  import ptmut_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_LINK  = 7'b0010000,
    S_LEAF  = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_READ;
        end
      end
      S_READ: state_d = S_EVAL;
      S_EVAL: begin
        if (!sts_i.level3) begin
          if (sts_i.link_ok) begin
            cmd_o.follow = 1'b1;
            state_d      = S_READ;
          end else begin
            state_d = S_RESP;
            unique case (sts_i.kind)
              KIND_MAP: begin
                if (sts_i.fits) begin
                  state_d = S_LINK;
                end else begin
                  cmd_o.res_set    = 1'b1;
                  cmd_o.res_status = ST_NO_TABLES;
                end
              end
              KIND_XLATE: begin
                cmd_o.res_set    = 1'b1;
                cmd_o.res_status = ST_NOT_MAPPED;
              end
              default: begin
                cmd_o.res_set    = 1'b1;
                cmd_o.res_status = ST_DONE;
              end
            endcase
          end
        end else begin
          unique case (sts_i.kind) inside
            KIND_MAP, KIND_UNMAP: state_d = S_LEAF;
            KIND_XLATE: begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_xlate  = sts_i.leaf_valid;
              cmd_o.res_status = sts_i.leaf_valid ? ST_DONE : ST_NOT_MAPPED;
              state_d          = S_RESP;
            end
            default: begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = ST_DONE;
              state_d          = S_RESP;
            end
          endcase
        end
      end
      S_LINK: begin
        cmd_o.alloc = 1'b1;
        if (sts_i.level2) state_d = S_LEAF;
      end
      S_LEAF: begin
        cmd_o.leaf_wr    = 1'b1;
        cmd_o.res_set    = 1'b1;
        cmd_o.res_status = ST_DONE;
        state_d          = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[sv/ptmut_dp.sv]
module ptmut_dp
  import ptmut_pkg::*;
#(
  parameter int unsigned TABLE_COUNT = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  kind_t            kind_i,
  input  logic [AddrW-1:0] virt_addr_i,
  input  logic [AddrW-1:0] phys_addr_in_i,
  input  logic [63:0]      attr_flags_i,
  output status_e          out_status_o,
  output logic [AddrW-1:0] out_phys_o
);

  localparam int unsigned TW    = $clog2(TABLE_COUNT);
  localparam int unsigned NW    = $clog2(TABLE_COUNT + 1);
  localparam int unsigned DEPTH = TABLE_COUNT * 512;
  localparam int unsigned AW    = $clog2(DEPTH);

  kind_t             kind_q;
  logic [AddrW-1:0]  va_q, pa_q;
  logic [63:0]       flags_q;
  logic [1:0]        level_q;
  logic [TW-1:0]     table_q;
  logic [NW-1:0]     next_free_q;
  logic [AW-1:0]     clr_cnt_q;
  status_e           res_status_q, out_status_q;
  logic [AddrW-1:0]  res_phys_q, out_phys_q;

  logic [IdxW-1:0]   idx;
  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [EntryW-1:0] mem_wdata, mem_rdata;
  logic [EntryW-1:0] leaf_val, link_val;
  logic [NW-1:0]     need, left;

  always_comb begin
    case (level_q)
      2'd0:    idx = va_q[47:39];
      2'd1:    idx = va_q[38:30];
      2'd2:    idx = va_q[29:21];
      default: idx = va_q[20:12];
    endcase
  end

  assign leaf_val = {16'd0, pa_q[47:PageLsb], {PageLsb{1'b0}}} | flags_q | EntryLowBits;
  assign link_val = (64'(next_free_q) << PageLsb) | EntryLowBits;

  assign mem_we   = cmd_i.clear_wr | cmd_i.alloc | cmd_i.leaf_wr;
  assign mem_addr = cmd_i.clear_wr ? clr_cnt_q : {table_q, idx};

  always_comb begin
    if (cmd_i.alloc) begin
      mem_wdata = link_val;
    end else if (cmd_i.leaf_wr && kind_q == KIND_MAP) begin
      mem_wdata = leaf_val;
    end else begin
      mem_wdata = '0;
    end
  end

  ptmut_ram #(
    .WIDTH(EntryW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  // tables still free against tables the walk lacks
  assign need = NW'(2'd3 - level_q);
  assign left = NW'(TABLE_COUNT) - next_free_q;

  always_comb begin
    sts_o            = '0;
    sts_o.kind       = kind_q;
    sts_o.level2     = (level_q == 2'd2);
    sts_o.level3     = (level_q == 2'd3);
    sts_o.link_ok    = mem_rdata[0] && (mem_rdata[47:PageLsb] < 36'(TABLE_COUNT));
    sts_o.leaf_valid = mem_rdata[0];
    sts_o.fits       = (need <= left);
    sts_o.clear_last = (clr_cnt_q == AW'(DEPTH - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_free_q <= NW'(1);
      clr_cnt_q   <= '0;
      level_q     <= '0;
      table_q     <= '0;
    end else begin
      if (cmd_i.clear_wr) clr_cnt_q <= clr_cnt_q + AW'(1);
      if (cmd_i.load_item) begin
        level_q <= '0;
        table_q <= '0;
      end else if (cmd_i.follow) begin
        level_q <= level_q + 2'd1;
        table_q <= mem_rdata[PageLsb +: TW];
      end else if (cmd_i.alloc) begin
        level_q     <= level_q + 2'd1;
        table_q     <= next_free_q[TW-1:0];
        next_free_q <= next_free_q + NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      kind_q  <= kind_i;
      va_q    <= virt_addr_i;
      pa_q    <= phys_addr_in_i;
      flags_q <= attr_flags_i;
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_phys_q   <= cmd_i.res_xlate ? {mem_rdata[47:PageLsb], va_q[PageLsb-1:0]} : '0;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_phys_q   <= res_phys_q;
    end
  end

  assign out_status_o = out_status_q;
  assign out_phys_o   = out_phys_q;

endmodule

[sv/ptmut_checker.sv]
module ptmut_checker
  import ptmut_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output changed while stalled");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser == ST_DONE || m_axis_tuser == ST_NOT_MAPPED ||
      m_axis_tuser == ST_NO_TABLES)
    else $error("undefined status");

  // address is zero unless the status is done
  a_phys_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_DONE |-> m_axis_tdata == '0)
    else $error("nonzero address with failing status");

  // one item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a transfer");

endmodule

bind page_table_map_unmap_translate_top ptmut_checker u_checker (.*);
